// ===== src/csvfs_pkg.sv =====
// Shared types and constants for the CSV field splitter and classifier.
// Used by every module of the block; depends on nothing.
package csvfs_pkg;

  // One request on the input channel.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_stream;
  } in_item_t;

  // One request on the output channel.
  typedef struct packed {
    logic [5:0] field_index;
    logic [1:0] field_class;
    logic [7:0] field_length;
    logic       last_in_line;
  } out_item_t;

  // Field classes as they appear on the output.
  localparam logic [1:0] CLS_EMPTY   = 2'd0;
  localparam logic [1:0] CLS_INTEGER = 2'd1;
  localparam logic [1:0] CLS_DECIMAL = 2'd2;
  localparam logic [1:0] CLS_TEXT    = 2'd3;

  // Byte values with a meaning of their own.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_COMMA   = 8'd44;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  // What kind of token a byte turns into.
  typedef enum logic [2:0] {
    TK_CONTENT,
    TK_SPACE,
    TK_QUOTE,
    TK_COMMA,
    TK_EOL
  } tok_kind_t;

  // Character class of a content byte.
  typedef enum logic [1:0] {
    CC_DIGIT,
    CC_DOT,
    CC_SIGN,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    tok_kind_t   kind;
    char_class_t cc;
  } token_t;

  // Classification phase of the field being built.
  typedef enum logic [2:0] {
    PH_START,
    PH_SIGN,
    PH_INT,
    PH_DEC,
    PH_TEXT
  } phase_t;

  // Token queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  function automatic phase_t next_phase(phase_t ph, char_class_t cc);
    phase_t r;
    r = PH_TEXT;
    case (ph)
      PH_START: begin
        case (cc)
          CC_SIGN:  r = PH_SIGN;
          CC_DIGIT: r = PH_INT;
          CC_DOT:   r = PH_DEC;
          default:  r = PH_TEXT;
        endcase
      end
      PH_SIGN, PH_INT: begin
        case (cc)
          CC_DIGIT: r = PH_INT;
          CC_DOT:   r = PH_DEC;
          default:  r = PH_TEXT;
        endcase
      end
      PH_DEC: begin
        r = (cc == CC_DIGIT) ? PH_DEC : PH_TEXT;
      end
      default: r = PH_TEXT;
    endcase
    return r;
  endfunction

endpackage

// ===== src/csvfs_front.sv =====
// Front end: turns each accepted byte into a token for the queue.
// Depends on csvfs_pkg.
module csvfs_front (
  input  csvfs_pkg::in_item_t item,
  output csvfs_pkg::token_t   tok
);
  import csvfs_pkg::*;

  always_comb begin
    tok.kind = TK_CONTENT;
    tok.cc   = CC_OTHER;
    if (item.end_of_stream || item.char_byte == CH_NEWLINE) begin
      tok.kind = TK_EOL;
    end else begin
      case (item.char_byte) inside
        CH_SPACE, CH_TAB, CH_CR: tok.kind = TK_SPACE;
        CH_QUOTE:                tok.kind = TK_QUOTE;
        CH_COMMA:                tok.kind = TK_COMMA;
        [CH_ZERO:CH_NINE]:       tok.cc   = CC_DIGIT;
        CH_DOT:                  tok.cc   = CC_DOT;
        CH_PLUS, CH_MINUS:       tok.cc   = CC_SIGN;
        default:                 tok.cc   = CC_OTHER;
      endcase
    end
  end

endmodule

// ===== src/csvfs_queue.sv =====
// Short token queue that decouples the front end from the field back end.
// Depends on csvfs_pkg.
module csvfs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csvfs_pkg::token_t wr_tok,
  output logic              full,
  input  logic              pop,
  output csvfs_pkg::token_t rd_tok,
  output logic              empty
);
  import csvfs_pkg::*;

  token_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full   = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/csvfs_back.sv =====
// Back end: per-line and per-field state, classification and the output register.
// Depends on csvfs_pkg.
module csvfs_back #(
  parameter int MAX_FIELD_LENGTH = 255,
  parameter int MAX_FIELDS       = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tok_avail,
  input  csvfs_pkg::token_t    tok,
  output logic                 tok_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvfs_pkg::out_item_t out_data
);
  import csvfs_pkg::*;

  localparam int LW = $clog2(MAX_FIELD_LENGTH + 1);
  localparam int CW = $clog2(MAX_FIELDS + 1);

  logic          quoted_mode,  quoted_mode_next;
  logic [CW-1:0] field_counter, field_counter_next;
  phase_t        class_phase,  class_phase_next;
  logic          content_seen, content_seen_next;
  logic [LW-1:0] pending_ws,   pending_ws_next;
  logic [LW-1:0] trimmed_len,  trimmed_len_next;
  logic          line_nonblank, line_nonblank_next;

  logic          emit;
  out_item_t     result;
  logic [LW:0]   len_sum;
  logic [1:0]    cls;

  // The output register takes a new result when it is empty or being drained.
  assign tok_pop = tok_avail && (!out_valid || out_ready);

  // Length with any held whitespace folded in, plus the new byte.
  assign len_sum = {1'b0, trimmed_len} + {1'b0, pending_ws} + (LW+1)'(1);

  always_comb begin
    if (!content_seen) begin
      cls = CLS_EMPTY;
    end else if (class_phase == PH_INT) begin
      cls = CLS_INTEGER;
    end else if (class_phase == PH_DEC) begin
      cls = CLS_DECIMAL;
    end else begin
      cls = CLS_TEXT;
    end
  end

  always_comb begin
    quoted_mode_next   = quoted_mode;
    field_counter_next = field_counter;
    class_phase_next   = class_phase;
    content_seen_next  = content_seen;
    pending_ws_next    = pending_ws;
    trimmed_len_next   = trimmed_len;
    line_nonblank_next = line_nonblank;
    emit               = 1'b0;

    result.field_index  = 6'(field_counter);
    result.field_class  = cls;
    result.field_length = 8'(trimmed_len);
    result.last_in_line = 1'b0;

    if (tok_pop) begin
      if (tok.kind == TK_EOL) begin
        emit                = line_nonblank;
        result.last_in_line = 1'b1;
        quoted_mode_next    = 1'b0;
        field_counter_next  = '0;
        line_nonblank_next  = 1'b0;
        class_phase_next    = PH_START;
        content_seen_next   = 1'b0;
        pending_ws_next     = '0;
        trimmed_len_next    = '0;
      end else begin
        if (tok.kind != TK_SPACE) line_nonblank_next = 1'b1;
        case (tok.kind)
          TK_QUOTE: begin
            quoted_mode_next = !quoted_mode;
          end
          TK_SPACE: begin
            if (content_seen && pending_ws != LW'(MAX_FIELD_LENGTH)) begin
              pending_ws_next = pending_ws + 1'b1;
            end
          end
          TK_COMMA, TK_CONTENT: begin
            if (tok.kind == TK_COMMA && !quoted_mode) begin
              emit = 1'b1;
              if (field_counter != CW'(MAX_FIELDS)) begin
                field_counter_next = field_counter + 1'b1;
              end
              class_phase_next  = PH_START;
              content_seen_next = 1'b0;
              pending_ws_next   = '0;
              trimmed_len_next  = '0;
            end else begin
              // A quoted comma is ordinary text. Held whitespace inside a
              // field makes it text before the new byte is classified.
              class_phase_next = next_phase(
                (content_seen && pending_ws != '0) ? PH_TEXT : class_phase,
                (tok.kind == TK_COMMA) ? CC_OTHER : tok.cc);
              content_seen_next = 1'b1;
              pending_ws_next   = '0;
              trimmed_len_next  = (len_sum > (LW+1)'(MAX_FIELD_LENGTH)) ?
                                  LW'(MAX_FIELD_LENGTH) : len_sum[LW-1:0];
            end
          end
          default: begin
            line_nonblank_next = line_nonblank;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quoted_mode   <= 1'b0;
      field_counter <= '0;
      class_phase   <= PH_START;
      content_seen  <= 1'b0;
      pending_ws    <= '0;
      trimmed_len   <= '0;
      line_nonblank <= 1'b0;
    end else begin
      quoted_mode   <= quoted_mode_next;
      field_counter <= field_counter_next;
      class_phase   <= class_phase_next;
      content_seen  <= content_seen_next;
      pending_ws    <= pending_ws_next;
      trimmed_len   <= trimmed_len_next;
      line_nonblank <= line_nonblank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

// ===== src/csv_field_splitter_classifier_core.sv =====
// CSV field splitter and classifier, top level.
// Path: a byte that closes a field passes the token queue and then the output register
// before its result shows; queued tokens and a held output register delay it further.
// Throughput: one byte per cycle while the output register is free or being drained.
// Reset: synchronous rst clears the token queue, all line and field state and out_valid.
// Depends on csvfs_pkg, csvfs_front, csvfs_queue and csvfs_back.
module csv_field_splitter_classifier_core #(
  parameter int MAX_FIELD_LENGTH = 255,
  parameter int MAX_FIELDS       = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvfs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvfs_pkg::out_item_t out_data
);
  import csvfs_pkg::*;

  // The front end sorts every byte into a token: line end, whitespace,
  // quote, comma or content with its character class. It knows nothing
  // about quoting or field state, so it never has to wait on the back end
  // except through the queue filling up.
  token_t front_tok;
  token_t back_tok;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  csvfs_front u_front (
    .item (in_data),
    .tok  (front_tok)
  );

  // A request is taken whenever the queue has room, independent of the
  // output side. Four entries let the front keep taking bytes while a
  // result waits on out_ready.
  assign in_ready = !q_full;

  csvfs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (in_valid && in_ready),
    .wr_tok (front_tok),
    .full   (q_full),
    .pop    (q_pop),
    .rd_tok (back_tok),
    .empty  (q_empty)
  );

  // The back end consumes one token per cycle whenever its output register
  // is free or being drained. It tracks quoted mode, the field index, the
  // running classification, trailing whitespace and the trimmed length, and
  // loads a result into the output register at each comma outside quotes
  // and at the end of a line that held anything but whitespace.
  csvfs_back #(
    .MAX_FIELD_LENGTH (MAX_FIELD_LENGTH),
    .MAX_FIELDS       (MAX_FIELDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_avail (!q_empty),
    .tok       (back_tok),
    .tok_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/csvfs_checker.sv =====
// Port-level checks for the CSV field splitter and classifier, and their bind.
// Depends on csvfs_pkg and csv_field_splitter_classifier_core.
module csvfs_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input csvfs_pkg::out_item_t out_data
);
  import csvfs_pkg::*;

  // A waiting result is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A waiting result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // A field with no content has zero length.
  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.field_class == CLS_EMPTY |-> out_data.field_length == 8'd0)
    else $error("empty field with nonzero length");

endmodule

bind csv_field_splitter_classifier_core csvfs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for csv_field_splitter_classifier_core: byte stimulus,
// a predictor of every field result in order, and a checker on the output channel.
// Depends on csvfs_pkg and the core RTL only.
module tb;
  import csvfs_pkg::*;

  localparam int FIELD_LEN_MAX = 255;
  localparam int FIELD_IDX_MAX = 63;
  localparam int RANDOM_BYTES  = 1300;
  // A result follows its closing byte through the queue and output register; a short drain is plenty.
  localparam int DRAIN_CYCLES  = 20;
  // Cycles with no request moving on either channel before the run is declared hung.
  localparam int STALL_LIMIT   = 400;
  localparam int REPORT_MAX    = 10;

  // One byte waiting to be driven, with the idle gap the driver leaves after it.
  typedef struct {
    in_item_t    req;
    int unsigned gap;
  } stim_entry_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stim_entry_t byte_queue[$];
  out_item_t   field_expect[$];

  // Predictor state: a private copy of the line and field tracking.
  bit          in_quotes;
  int unsigned field_pos;
  phase_t      field_phase;
  bit          has_content;
  int unsigned held_ws;
  int unsigned field_len;
  bit          line_nonblank;

  bit          calm;
  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned lines_seen;
  int unsigned fields_checked;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;

  csv_field_splitter_classifier_core #(
    .MAX_FIELD_LENGTH(FIELD_LEN_MAX),
    .MAX_FIELDS      (FIELD_IDX_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned sat_len(int unsigned v);
    return (v > FIELD_LEN_MAX) ? FIELD_LEN_MAX : v;
  endfunction

  // Classification walk: a sign may lead, digits keep a number integral, a single
  // dot turns it decimal, and anything else makes the field text for good.
  function automatic phase_t advance_phase(phase_t ph, logic [7:0] c);
    bit     digit;
    bit     dot;
    bit     sgn;
    phase_t r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dot   = (c == CH_DOT);
    sgn   = (c == CH_PLUS) || (c == CH_MINUS);
    r     = PH_TEXT;
    case (ph)
      PH_START: begin
        if (sgn) r = PH_SIGN;
        else if (digit) r = PH_INT;
        else if (dot) r = PH_DEC;
      end
      PH_SIGN, PH_INT: begin
        if (digit) r = PH_INT;
        else if (dot) r = PH_DEC;
      end
      PH_DEC: begin
        if (digit) r = PH_DEC;
      end
      default: r = PH_TEXT;
    endcase
    return r;
  endfunction

  task automatic restart_field();
    field_phase = PH_START;
    has_content = 1'b0;
    held_ws     = 0;
    field_len   = 0;
  endtask

  task automatic expect_field(input bit last);
    out_item_t e;
    e.field_index  = field_pos[5:0];
    if (!has_content) e.field_class = CLS_EMPTY;
    else if (field_phase == PH_INT) e.field_class = CLS_INTEGER;
    else if (field_phase == PH_DEC) e.field_class = CLS_DECIMAL;
    else e.field_class = CLS_TEXT;
    e.field_length = field_len[7:0];
    e.last_in_line = last;
    field_expect = {field_expect, e};
  endtask

  // Advances the predictor by one accepted byte and queues any field it closes.
  task automatic tokenize_byte(input in_item_t req);
    logic [7:0] c;
    bit         blank;
    c     = req.char_byte;
    blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    if (req.end_of_stream || c == CH_NEWLINE) begin
      // A line end closes the last field even inside quotes; blank lines say nothing.
      if (line_nonblank) expect_field(1'b1);
      lines_seen++;
      in_quotes     = 1'b0;
      field_pos     = 0;
      line_nonblank = 1'b0;
      restart_field();
    end else begin
      if (!blank) line_nonblank = 1'b1;
      if (c == CH_QUOTE) begin
        in_quotes = !in_quotes;
      end else if (c == CH_COMMA && !in_quotes) begin
        expect_field(1'b0);
        if (field_pos < FIELD_IDX_MAX) field_pos++;
        restart_field();
      end else if (blank) begin
        // Whitespace is held back until content follows, which trims the tail.
        if (has_content) held_ws = sat_len(held_ws + 1);
      end else begin
        if (has_content && held_ws != 0) begin
          field_phase = PH_TEXT;
          field_len   = sat_len(field_len + held_ws);
          held_ws     = 0;
        end
        field_phase = advance_phase(field_phase, c);
        has_content = 1'b1;
        field_len   = sat_len(field_len + 1);
      end
    end
  endtask

  task automatic check_field(input out_item_t got);
    out_item_t want;
    bit        bad;
    if (field_expect.size() == 0) begin
      if (mismatches < REPORT_MAX) begin
        $display("%0t: unexpected field idx=%0d cls=%0d len=%0d last=%0d", $realtime,
                 got.field_index, got.field_class, got.field_length, got.last_in_line);
      end
      mismatches++;
    end else begin
      want = field_expect.pop_front();
      fields_checked++;
      bad = (got.field_index != want.field_index) || (got.field_class != want.field_class) ||
            (got.field_length != want.field_length) ||
            (got.last_in_line != want.last_in_line);
      if (bad) begin
        if (mismatches < REPORT_MAX) begin
          $display("%0t: field mismatch exp idx=%0d cls=%0d len=%0d last=%0d", $realtime,
                   want.field_index, want.field_class, want.field_length, want.last_in_line);
          $display("%0t:                got idx=%0d cls=%0d len=%0d last=%0d", $realtime,
                   got.field_index, got.field_class, got.field_length, got.last_in_line);
        end
        mismatches++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input bit eos);
    stim_entry_t e;
    e.req.char_byte     = b;
    e.req.end_of_stream = eos;
    e.gap               = calm ? 0 : $urandom_range(0, 5);
    byte_queue = {byte_queue, e};
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Any non-blank byte that does not act as a separator, high bytes included.
  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) :
                                        8'($urandom_range(33, 126));
    end while (b == CH_QUOTE || b == CH_COMMA);
    return b;
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus, end of run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned line_no;
    int unsigned target;
    int unsigned nf;
    int unsigned kind;

    calm = 1'b0;
    // Integer, decimal and text fields, a quoted comma and a lone sign, closed by end-of-stream on a stray byte.
    push_text("-7, 4.2 ,\"a,b\",+");
    push_byte(8'hFF, 1'b1);
    // A line of whitespace only, then a line with no bytes at all.
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte(CH_NEWLINE, 1'b0);
    push_byte(CH_NEWLINE, 1'b0);
    // Sign with a dot, a lone dot, and a newline that lands inside quotes.
    push_text("-.,.,\"x\n");
    // Inner whitespace, an empty field, a zero byte, closed by end-of-stream on a newline.
    push_text("a b,,");
    push_byte(8'h00, 1'b0);
    push_byte(CH_NEWLINE, 1'b1);

    target  = bytes_queued + RANDOM_BYTES;
    line_no = 0;
    while (bytes_queued < target) begin
      calm = (line_no % 6 == 5);
      if (line_no == 3) begin
        // More fields than the index can count.
        for (int i = 0; i < 66; i++) begin
          push_byte(CH_ZERO + 8'(i % 10), 1'b0);
          push_byte(CH_COMMA, 1'b0);
        end
        push_byte(CH_NEWLINE, 1'b0);
      end else if (line_no == 7) begin
        // Inner whitespace long enough to saturate both held space and length.
        push_text("a");
        repeat (260) push_byte(CH_SPACE, 1'b0);
        push_text("b,7");
        push_byte(CH_NEWLINE, 1'b0);
      end else begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          repeat ($urandom_range(0, 3)) push_byte(pick_blank(), 1'b0);
        end else if (kind < 3) begin
          // Raw noise: stray quotes, newlines and control bytes in any order.
          repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          nf = $urandom_range(1, 6);
          for (int f = 0; f < nf; f++) begin
            if (f > 0) push_byte(CH_COMMA, 1'b0);
            repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
            case ($urandom_range(0, 6))
              0: begin
              end
              1: begin
                if ($urandom_range(0, 1)) push_byte(pick_sign(), 1'b0);
                repeat ($urandom_range(1, 4)) push_byte(pick_digit(), 1'b0);
              end
              2: begin
                if ($urandom_range(0, 1)) push_byte(pick_sign(), 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(pick_digit(), 1'b0);
                push_byte(CH_DOT, 1'b0);
                repeat ($urandom_range(0, 3)) push_byte(pick_digit(), 1'b0);
              end
              3: begin
                repeat ($urandom_range(1, 5)) push_byte(pick_text(), 1'b0);
              end
              4: begin
                push_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                  case ($urandom_range(0, 3))
                    0:       push_byte(CH_COMMA, 1'b0);
                    1:       push_byte(pick_blank(), 1'b0);
                    2:       push_byte(pick_digit(), 1'b0);
                    default: push_byte(pick_text(), 1'b0);
                  endcase
                end
                // Now and then the closing quote goes missing.
                if ($urandom_range(0, 7) != 0) push_byte(CH_QUOTE, 1'b0);
              end
              5: begin
                // Near-numbers: a second dot or a sign in the middle.
                push_byte(pick_digit(), 1'b0);
                push_byte($urandom_range(0, 1) ? CH_DOT : pick_sign(), 1'b0);
                push_byte(pick_digit(), 1'b0);
                push_byte($urandom_range(0, 1) ? CH_DOT : pick_digit(), 1'b0);
              end
              default: begin
                repeat ($urandom_range(1, 3)) push_byte(pick_digit(), 1'b0);
                push_byte(pick_blank(), 1'b0);
                repeat ($urandom_range(1, 3)) push_byte(pick_digit(), 1'b0);
              end
            endcase
            repeat ($urandom_range(0, 2)) push_byte(pick_blank(), 1'b0);
          end
        end
        if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(0, 255)), 1'b1);
        else push_byte(CH_NEWLINE, 1'b0);
      end
      line_no++;
    end

    // Sample on the falling edge so every clocked update of the cycle has settled.
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || bytes_taken != bytes_queued ||
           field_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (field_expect.size() != 0) begin
      $display("%0d expected fields never arrived", field_expect.size());
      mismatches += field_expect.size();
    end
    $display("Tokenized %0d bytes across %0d lines and checked %0d fields.",
             bytes_taken, lines_seen, fields_checked);
    $display("Errors found: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: ends a run in which no request moves for too long.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, holding each until accepted, then idles for its gap.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_bytes
    stim_entry_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        nxt = byte_queue.pop_front();
        in_data  <= nxt.req;
        in_valid <= 1'b1;
        gap_left <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts from accepted bytes before checking, so a result can never
  // be compared ahead of the byte that caused it. Also paces out_ready.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_fields
    bit          moved;
    int unsigned s;
    if (rst) begin
      out_ready   <= 1'b0;
      stall_left  <= 0;
      idle_cycles <= 0;
      in_quotes     = 1'b0;
      field_pos     = 0;
      line_nonblank = 1'b0;
      restart_field();
    end else begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        tokenize_byte(in_data);
        bytes_taken++;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        check_field(out_data);
        moved = 1'b1;
        // Some stretches of results see no back-pressure at all.
        s = ((fields_checked / 50) % 3 == 2) ? 0 : $urandom_range(0, 5);
        out_ready  <= (s == 0);
        stall_left <= s;
      end else if (!out_ready) begin
        if (stall_left <= 1) begin
          out_ready  <= 1'b1;
          stall_left <= 0;
        end else begin
          stall_left <= stall_left - 1;
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

endmodule
